[rtl/core/spc_pkg.sv]
// Shared types, widths and helpers for the shape pair collision test.
package spc_pkg;

	// Field widths
	localparam int COORD_BITS      = 24;
	localparam int SIZE_W          = 23;
	localparam int SQRT_ITERATIONS = 24;
	localparam int NORM_W          = 16;
	localparam int PEN_W           = 25;

	// Internal geometry in Q.9
	localparam int POS_W  = COORD_BITS + 1;
	localparam int EDGE_W = POS_W + 1;
	localparam int DIFF_W = EDGE_W + 1;
	localparam int RAD_W  = SIZE_W + 1;
	localparam int SQ_W   = 2 * RAD_W;
	localparam int MAG_W  = SQRT_ITERATIONS;

	// Divider geometry
	localparam int QUO_W      = 24;
	localparam int NUM_W      = 50;
	localparam int DEN_W      = MAG_W + 1;
	localparam int NORM_SHIFT = 14;

	localparam logic signed [NORM_W-1:0] NORM_ONE  = 16'sd16384;
	localparam logic signed [NORM_W-1:0] NORM_DIAG = 16'sd11585;
	localparam logic signed [PEN_W-1:0]  PEN_MAX   = 25'sh0FFFFFF;
	localparam logic signed [PEN_W-1:0]  PEN_MIN   = 25'sh1000000;
	localparam logic [DIFF_W-1:0]        PEN_LIM   = DIFF_W'(1) << (PEN_W - 1);

	typedef enum logic {
		SHAPE_BOX    = 1'b0,
		SHAPE_CIRCLE = 1'b1
	} shape_t;

	// Side data that travels along the pipeline with each item
	typedef struct packed {
		logic                     hit;
		logic                     round;
		logic                     zero;
		logic                     sgn_x;
		logic                     sgn_y;
		logic [RAD_W-1:0]         ad_x;
		logic [RAD_W-1:0]         ad_y;
		logic [RAD_W-1:0]         rad;
		logic signed [NORM_W-1:0] bnx;
		logic signed [NORM_W-1:0] bny;
		logic signed [PEN_W-1:0]  bpx;
		logic signed [PEN_W-1:0]  bpy;
	} side_t;

	// Halve a Q.9 penetration to Q.8, round half away from zero, saturate
	function automatic logic signed [PEN_W-1:0] pen_half(input logic signed [DIFF_W-1:0] p);
		logic [DIFF_W-1:0] ap;
		logic [DIFF_W-1:0] h;
		logic signed [PEN_W-1:0] r;
		ap = p[DIFF_W-1] ? DIFF_W'(-p) : DIFF_W'(p);
		h  = (ap + DIFF_W'(1)) >> 1;
		if (p[DIFF_W-1]) begin
			r = (h > PEN_LIM) ? PEN_MIN : -$signed(PEN_W'(h));
		end else begin
			r = (h >= PEN_LIM) ? PEN_MAX : $signed(PEN_W'(h));
		end
		return r;
	endfunction

endpackage

[rtl/core/spc_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module spc_div import spc_pkg::*; (
	input  logic             clk,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [QUO_W-1:0] quo
);

	logic [NUM_W-1:0] rem_s [0:QUO_W];
	logic [DEN_W-1:0] den_s [0:QUO_W];
	logic [QUO_W-1:0] quo_s [0:QUO_W];

	assign rem_s[0] = num;
	assign den_s[0] = den;
	assign quo_s[0] = '0;

	// Resolve one quotient bit per stage, most significant first
	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		localparam int B = QUO_W - 1 - k;
		logic [NUM_W-1:0] sub;
		assign sub = NUM_W'(den_s[k]) << B;
		always_ff @(posedge clk) begin
			den_s[k+1] <= den_s[k];
			if (rem_s[k] >= sub) begin
				rem_s[k+1] <= rem_s[k] - sub;
				quo_s[k+1] <= quo_s[k] | (QUO_W'(1) << B);
			end else begin
				rem_s[k+1] <= rem_s[k];
				quo_s[k+1] <= quo_s[k];
			end
		end
	end

	assign quo = quo_s[QUO_W];

endmodule

[rtl/core/shape_pair_collision_test_unit.sv]
// Top level of the shape pair collision test pipeline.
// One shape pair is taken on every clock at which start is high; busy never rises. The hit
// flag, normal and penetration for that pair show on the result ports for one cycle, marked
// by done, after the registered stages, in input order. The receiver cannot hold results
// off, so the pipeline never stalls. Most stages belong to the 24-step integer square root
// and the 24-step dividers for the normal and penetration, each one stage per bit.
module shape_pair_collision_test_unit import spc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     a_shape,
	input  logic signed [COORD_BITS-1:0] a_center_x,
	input  logic signed [COORD_BITS-1:0] a_center_y,
	input  logic [SIZE_W-1:0]        a_width,
	input  logic [SIZE_W-1:0]        a_height,
	input  logic                     b_shape,
	input  logic signed [COORD_BITS-1:0] b_center_x,
	input  logic signed [COORD_BITS-1:0] b_center_y,
	input  logic [SIZE_W-1:0]        b_width,
	input  logic [SIZE_W-1:0]        b_height,
	output logic                     done,
	output logic                     hit,
	output logic signed [NORM_W-1:0] normal_x,
	output logic signed [NORM_W-1:0] normal_y,
	output logic signed [PEN_W-1:0]  pen_x,
	output logic signed [PEN_W-1:0]  pen_y
);

	assign busy = 1'b0;

	// ---------------- stage 1: box edges and centers in Q.9
	logic signed [POS_W-1:0]  xa, ya, xb, yb;
	logic signed [EDGE_W-1:0] wa_e, ha_e, wb_e, hb_e;
	logic [RAD_W-1:0]         rad_c;
	logic a_circ, b_circ;

	logic v_s1;
	logic a_circ_s1, b_circ_s1;
	logic signed [POS_W-1:0]  xa_s1, ya_s1, xb_s1, yb_s1;
	logic signed [EDGE_W-1:0] alx_s1, ahx_s1, aly_s1, ahy_s1;
	logic signed [EDGE_W-1:0] blx_s1, bhx_s1, bly_s1, bhy_s1;
	logic [RAD_W-1:0]         rad_s1;

	always_comb begin
		xa = $signed({a_center_x, 1'b0});
		ya = $signed({a_center_y, 1'b0});
		xb = $signed({b_center_x, 1'b0});
		yb = $signed({b_center_y, 1'b0});
		wa_e = EDGE_W'(a_width);
		ha_e = EDGE_W'(a_height);
		wb_e = EDGE_W'(b_width);
		hb_e = EDGE_W'(b_height);
		a_circ = (shape_t'(a_shape) == SHAPE_CIRCLE);
		b_circ = (shape_t'(b_shape) == SHAPE_CIRCLE);
		if (a_circ && b_circ) begin
			rad_c = RAD_W'(a_width) + RAD_W'(b_width);
		end else if (a_circ) begin
			rad_c = RAD_W'(a_width);
		end else begin
			rad_c = RAD_W'(b_width);
		end
	end

	always_ff @(posedge clk) begin
		a_circ_s1 <= a_circ;
		b_circ_s1 <= b_circ;
		xa_s1 <= xa;
		ya_s1 <= ya;
		xb_s1 <= xb;
		yb_s1 <= yb;
		alx_s1 <= EDGE_W'(xa) - wa_e;
		ahx_s1 <= EDGE_W'(xa) + wa_e;
		aly_s1 <= EDGE_W'(ya) - ha_e;
		ahy_s1 <= EDGE_W'(ya) + ha_e;
		blx_s1 <= EDGE_W'(xb) - wb_e;
		bhx_s1 <= EDGE_W'(xb) + wb_e;
		bly_s1 <= EDGE_W'(yb) - hb_e;
		bhy_s1 <= EDGE_W'(yb) + hb_e;
		rad_s1 <= rad_c;
	end

	// ---------------- stage 2: box overlap, closest box point
	logic signed [EDGE_W-1:0] lox, hix, loy, hiy, cenx_e, ceny_e, qx, qy;
	logic cc, flip;

	logic v_s2;
	logic round_s2, flip_s2, ovx_s2, ovy_s2, bx_s2, by_s2;
	logic signed [DIFF_W-1:0] px_s2, py_s2;
	logic signed [EDGE_W-1:0] qx_s2, qy_s2, cx_s2, cy_s2;
	logic [RAD_W-1:0]         rad_s2;

	always_comb begin
		cc   = a_circ_s1 && b_circ_s1;
		flip = !a_circ_s1;
		if (!a_circ_s1) begin
			lox = alx_s1; hix = ahx_s1; loy = aly_s1; hiy = ahy_s1;
			cenx_e = EDGE_W'(xb_s1);
			ceny_e = EDGE_W'(yb_s1);
		end else begin
			lox = blx_s1; hix = bhx_s1; loy = bly_s1; hiy = bhy_s1;
			cenx_e = EDGE_W'(xa_s1);
			ceny_e = EDGE_W'(ya_s1);
		end
		if (cc) begin
			qx = EDGE_W'(xb_s1);
			qy = EDGE_W'(yb_s1);
		end else begin
			qx = (cenx_e < lox) ? lox : ((cenx_e > hix) ? hix : cenx_e);
			qy = (ceny_e < loy) ? loy : ((ceny_e > hiy) ? hiy : ceny_e);
		end
	end

	always_ff @(posedge clk) begin
		round_s2 <= a_circ_s1 || b_circ_s1;
		flip_s2  <= flip;
		ovx_s2   <= !(ahx_s1 < blx_s1 || alx_s1 > bhx_s1);
		ovy_s2   <= !(ahy_s1 < bly_s1 || aly_s1 > bhy_s1);
		bx_s2    <= xa_s1 < xb_s1;
		by_s2    <= ya_s1 < yb_s1;
		px_s2    <= (xa_s1 < xb_s1) ? DIFF_W'(ahx_s1) - DIFF_W'(blx_s1)
		                            : DIFF_W'(alx_s1) - DIFF_W'(bhx_s1);
		py_s2    <= (ya_s1 < yb_s1) ? DIFF_W'(ahy_s1) - DIFF_W'(bly_s1)
		                            : DIFF_W'(aly_s1) - DIFF_W'(bhy_s1);
		qx_s2    <= qx;
		qy_s2    <= qy;
		cx_s2    <= cc ? EDGE_W'(xa_s1) : cenx_e;
		cy_s2    <= cc ? EDGE_W'(ya_s1) : ceny_e;
		rad_s2   <= rad_s1;
	end

	// ---------------- stage 3: contact vector, box-box results
	logic [DIFF_W-1:0] bax, bay;
	side_t side_c3;

	logic v_s3;
	logic signed [DIFF_W-1:0] dx_s3, dy_s3;
	side_t side_s3;

	always_comb begin
		bax = px_s2[DIFF_W-1] ? DIFF_W'(-px_s2) : DIFF_W'(px_s2);
		bay = py_s2[DIFF_W-1] ? DIFF_W'(-py_s2) : DIFF_W'(py_s2);
		side_c3       = '0;
		side_c3.round = round_s2;
		side_c3.rad   = rad_s2;
		side_c3.hit   = ovx_s2 && ovy_s2;
		if (ovx_s2 && ovy_s2) begin
			if (bax > bay) begin
				side_c3.bny = by_s2 ? -NORM_ONE : NORM_ONE;
			end else if (bay > bax) begin
				side_c3.bnx = bx_s2 ? -NORM_ONE : NORM_ONE;
			end else begin
				side_c3.bnx = bx_s2 ? -NORM_DIAG : NORM_DIAG;
				side_c3.bny = by_s2 ? -NORM_DIAG : NORM_DIAG;
			end
			side_c3.bpx = pen_half(px_s2);
			side_c3.bpy = pen_half(py_s2);
		end
	end

	always_ff @(posedge clk) begin
		dx_s3   <= flip_s2 ? DIFF_W'(cx_s2) - DIFF_W'(qx_s2) : DIFF_W'(qx_s2) - DIFF_W'(cx_s2);
		dy_s3   <= flip_s2 ? DIFF_W'(cy_s2) - DIFF_W'(qy_s2) : DIFF_W'(qy_s2) - DIFF_W'(cy_s2);
		side_s3 <= side_c3;
	end

	// ---------------- stage 4: far test and squares
	logic [DIFF_W-1:0] adx, ady;
	side_t side_c4;

	logic v_s4;
	logic far_s4;
	logic [SQ_W-1:0] sqx_s4, sqy_s4, radsq_s4;
	side_t side_s4;

	always_comb begin
		adx = dx_s3[DIFF_W-1] ? DIFF_W'(-dx_s3) : DIFF_W'(dx_s3);
		ady = dy_s3[DIFF_W-1] ? DIFF_W'(-dy_s3) : DIFF_W'(dy_s3);
		side_c4       = side_s3;
		side_c4.sgn_x = dx_s3[DIFF_W-1];
		side_c4.sgn_y = dy_s3[DIFF_W-1];
		side_c4.ad_x  = adx[RAD_W-1:0];
		side_c4.ad_y  = ady[RAD_W-1:0];
	end

	always_ff @(posedge clk) begin
		far_s4   <= (adx > DIFF_W'(side_s3.rad)) || (ady > DIFF_W'(side_s3.rad));
		sqx_s4   <= SQ_W'(adx[RAD_W-1:0]) * SQ_W'(adx[RAD_W-1:0]);
		sqy_s4   <= SQ_W'(ady[RAD_W-1:0]) * SQ_W'(ady[RAD_W-1:0]);
		radsq_s4 <= SQ_W'(side_s3.rad) * SQ_W'(side_s3.rad);
		side_s4  <= side_c4;
	end

	// ---------------- stage 5 and square root: one root bit per stage
	logic [SQ_W:0] sum;
	logic in_reach;
	side_t side_c5;

	logic            vld_sq_s  [0:SQRT_ITERATIONS];
	logic [SQ_W-1:0] rem_sq_s  [0:SQRT_ITERATIONS];
	logic [MAG_W-1:0] root_sq_s [0:SQRT_ITERATIONS];
	side_t           side_sq_s [0:SQRT_ITERATIONS];

	always_comb begin
		sum      = (SQ_W+1)'(sqx_s4) + (SQ_W+1)'(sqy_s4);
		in_reach = !far_s4 && (sum <= (SQ_W+1)'(radsq_s4));
		side_c5  = side_s4;
		if (side_s4.round) begin
			side_c5.hit = in_reach;
		end
	end

	always_ff @(posedge clk) begin
		rem_sq_s[0]  <= in_reach ? sum[SQ_W-1:0] : '0;
		root_sq_s[0] <= '0;
		side_sq_s[0] <= side_c5;
	end

	for (genvar k = 0; k < SQRT_ITERATIONS; k++) begin : g_sqrt
		localparam int B = SQRT_ITERATIONS - 1 - k;
		logic [SQ_W:0] trial;
		assign trial = ((SQ_W+1)'(root_sq_s[k]) << (B + 1)) | ((SQ_W+1)'(1) << (2 * B));
		always_ff @(posedge clk) begin
			side_sq_s[k+1] <= side_sq_s[k];
			if ((SQ_W+1)'(rem_sq_s[k]) >= trial) begin
				rem_sq_s[k+1]  <= rem_sq_s[k] - trial[SQ_W-1:0];
				root_sq_s[k+1] <= root_sq_s[k] | (MAG_W'(1) << B);
			end else begin
				rem_sq_s[k+1]  <= rem_sq_s[k];
				root_sq_s[k+1] <= root_sq_s[k];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sq_s[k+1] <= 1'b0;
			end else begin
				vld_sq_s[k+1] <= vld_sq_s[k];
			end
		end
	end

	// ---------------- stage 6: depth products
	logic [MAG_W-1:0] mag;
	logic [RAD_W-1:0] depth;

	logic v_s6;
	logic [MAG_W-1:0] m_s6;
	logic [SQ_W-1:0]  prx_s6, pry_s6;
	side_t side_s6;

	always_comb begin
		mag   = root_sq_s[SQRT_ITERATIONS];
		depth = side_sq_s[SQRT_ITERATIONS].rad - RAD_W'(mag);
	end

	always_ff @(posedge clk) begin
		m_s6    <= mag;
		prx_s6  <= SQ_W'(side_sq_s[SQRT_ITERATIONS].ad_x) * SQ_W'(depth);
		pry_s6  <= SQ_W'(side_sq_s[SQRT_ITERATIONS].ad_y) * SQ_W'(depth);
		side_s6 <= side_sq_s[SQRT_ITERATIONS];
	end

	// ---------------- stage 7: rounded numerators and divisors
	side_t side_c7;

	logic v_s7;
	logic [NUM_W-1:0] nnx_s7, nny_s7, npx_s7, npy_s7;
	logic [DEN_W-1:0] dn_s7, dp_s7;
	side_t side_s7;

	always_comb begin
		side_c7      = side_s6;
		side_c7.zero = (m_s6 == '0);
	end

	always_ff @(posedge clk) begin
		nnx_s7  <= (NUM_W'(side_s6.ad_x) << NORM_SHIFT) + NUM_W'(m_s6 >> 1);
		nny_s7  <= (NUM_W'(side_s6.ad_y) << NORM_SHIFT) + NUM_W'(m_s6 >> 1);
		npx_s7  <= NUM_W'(prx_s6) + NUM_W'(m_s6);
		npy_s7  <= NUM_W'(pry_s6) + NUM_W'(m_s6);
		dn_s7   <= DEN_W'(m_s6);
		dp_s7   <= {m_s6, 1'b0};
		side_s7 <= side_c7;
	end

	// ---------------- dividers
	logic [QUO_W-1:0] qnx, qny, qpx, qpy;

	spc_div u_div_nx (.clk(clk), .num(nnx_s7), .den(dn_s7), .quo(qnx));
	spc_div u_div_ny (.clk(clk), .num(nny_s7), .den(dn_s7), .quo(qny));
	spc_div u_div_px (.clk(clk), .num(npx_s7), .den(dp_s7), .quo(qpx));
	spc_div u_div_py (.clk(clk), .num(npy_s7), .den(dp_s7), .quo(qpy));

	logic  vld_dv_s  [0:QUO_W];
	side_t side_dv_s [0:QUO_W];

	assign vld_dv_s[0]  = v_s7;
	assign side_dv_s[0] = side_s7;

	// Carry side data alongside the divider stages
	for (genvar k = 0; k < QUO_W; k++) begin : g_dside
		always_ff @(posedge clk) begin
			side_dv_s[k+1] <= side_dv_s[k];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_dv_s[k+1] <= 1'b0;
			end else begin
				vld_dv_s[k+1] <= vld_dv_s[k];
			end
		end
	end

	// ---------------- output register
	side_t fs;
	logic signed [NORM_W-1:0] nx_c, ny_c;
	logic signed [PEN_W-1:0]  px_c, py_c;

	always_comb begin
		fs = side_dv_s[QUO_W];
		if (!fs.round) begin
			nx_c = fs.bnx;
			ny_c = fs.bny;
			px_c = fs.bpx;
			py_c = fs.bpy;
		end else if (!fs.hit || fs.zero) begin
			nx_c = '0;
			ny_c = '0;
			px_c = '0;
			py_c = '0;
		end else begin
			nx_c = fs.sgn_x ? $signed(NORM_W'(qnx)) : -$signed(NORM_W'(qnx));
			ny_c = fs.sgn_y ? $signed(NORM_W'(qny)) : -$signed(NORM_W'(qny));
			px_c = fs.sgn_x ? -$signed(PEN_W'(qpx)) : $signed(PEN_W'(qpx));
			py_c = fs.sgn_y ? -$signed(PEN_W'(qpy)) : $signed(PEN_W'(qpy));
		end
	end

	always_ff @(posedge clk) begin
		hit      <= fs.hit;
		normal_x <= nx_c;
		normal_y <= ny_c;
		pen_x    <= px_c;
		pen_y    <= py_c;
	end

	// ---------------- valid bits for the fixed stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			vld_sq_s[0] <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			done        <= 1'b0;
		end else begin
			v_s1        <= start && !busy;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			vld_sq_s[0] <= v_s4;
			v_s6        <= vld_sq_s[SQRT_ITERATIONS];
			v_s7        <= v_s6;
			done        <= vld_dv_s[QUO_W];
		end
	end

	// ---------------- assertions
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> v_s1)
		else $error("accepted pair did not enter the pipeline");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !hit |-> normal_x == '0 && normal_y == '0 && pen_x == '0 && pen_y == '0)
		else $error("miss carries a nonzero normal or penetration");

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> normal_x <= NORM_ONE && normal_x >= -NORM_ONE &&
		         normal_y <= NORM_ONE && normal_y >= -NORM_ONE)
		else $error("normal out of unit range");

endmodule
